FILE: hw/rtl/pngu_pkg.sv
package pngu_pkg;

  // Palette size and the widths that follow from it
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalIdxW        = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;
  localparam int unsigned PalCntW        = $clog2(PaletteEntries + 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Supported sample depths
  localparam logic [4:0] Depth1  = 5'd1;
  localparam logic [4:0] Depth2  = 5'd2;
  localparam logic [4:0] Depth4  = 5'd4;
  localparam logic [4:0] Depth8  = 5'd8;
  localparam logic [4:0] Depth16 = 5'd16;

  localparam logic [15:0] AlphaOpaque = 16'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColorKind   = 2'd0,
    CfgSampleDepth = 2'd1,
    CfgTransCount  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KindGray      = 3'd0,
    KindRgb       = 3'd1,
    KindPalette   = 3'd2,
    KindGrayAlpha = 3'd3,
    KindRgba      = 3'd4
  } color_kind_e;

  // Decoded pixel handed from the unpack stage to the palette stage
  typedef struct packed {
    logic        pal;        // palette pixel, color comes from the RAM
    logic        in_range;   // index below PaletteEntries
    logic        use_trans;  // index below trans_count
    logic [7:0]  idx;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pngu_stage_t;

endpackage

FILE: hw/rtl/pngu_in_if.sv
interface pngu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] pixel_bytes;
  logic [2:0]  pixel_position;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic [7:0]  entry_alpha;

  modport source (
    output valid, func, pixel_bytes, pixel_position, entry_index,
           entry_red, entry_green, entry_blue, entry_alpha,
    input  ready
  );

  modport sink (
    input  valid, func, pixel_bytes, pixel_position, entry_index,
           entry_red, entry_green, entry_blue, entry_alpha,
    output ready
  );
endinterface

FILE: hw/rtl/pngu_out_if.sv
interface pngu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out,
    output ready
  );
endinterface

FILE: hw/rtl/pngu_unpack.sv
module pngu_unpack
  import pngu_pkg::*;
(
  input  logic [63:0]  pixel_bytes_i,
  input  logic [2:0]   pixel_position_i,
  input  logic [2:0]   color_kind_i,
  input  logic [4:0]   sample_depth_i,
  input  logic [8:0]   trans_count_i,
  output pngu_stage_t  stage_o
);

  logic [15:0] pair0, pair1, pair2, pair3;
  logic [7:0]  byte0, byte1, byte2, byte3;
  logic [7:0]  sub_val;
  logic [7:0]  mask;
  logic [2:0]  sh;
  logic        wide;

  assign pair0 = pixel_bytes_i[63:48];
  assign pair1 = pixel_bytes_i[47:32];
  assign pair2 = pixel_bytes_i[31:16];
  assign pair3 = pixel_bytes_i[15:0];
  assign byte0 = pixel_bytes_i[63:56];
  assign byte1 = pixel_bytes_i[55:48];
  assign byte2 = pixel_bytes_i[47:40];
  assign byte3 = pixel_bytes_i[39:32];
  assign wide  = (sample_depth_i == Depth16);

  // MSB-first sub-byte sample select
  always_comb begin
    unique case (sample_depth_i)
      Depth1: begin
        sh   = 3'd7 - pixel_position_i;
        mask = 8'h01;
      end
      Depth2: begin
        sh   = 3'd6 - {pixel_position_i[1:0], 1'b0};
        mask = 8'h03;
      end
      Depth4: begin
        sh   = pixel_position_i[0] ? 3'd0 : 3'd4;
        mask = 8'h0F;
      end
      default: begin
        sh   = 3'd0;
        mask = 8'hFF;
      end
    endcase
    sub_val = (byte0 >> sh) & mask;
  end

  always_comb begin
    stage_o           = '0;
    stage_o.idx       = wide ? byte0 : sub_val;
    stage_o.in_range  = ({1'b0, stage_o.idx} < 9'(PaletteEntries));
    stage_o.use_trans = ({1'b0, stage_o.idx} < trans_count_i);
    unique case (color_kind_i)
      KindGray: begin
        stage_o.red   = wide ? pair0 : {8'd0, sub_val};
        stage_o.green = stage_o.red;
        stage_o.blue  = stage_o.red;
        stage_o.alpha = AlphaOpaque;
      end
      KindRgb: begin
        stage_o.red   = wide ? pair0 : {8'd0, byte0};
        stage_o.green = wide ? pair1 : {8'd0, byte1};
        stage_o.blue  = wide ? pair2 : {8'd0, byte2};
        stage_o.alpha = AlphaOpaque;
      end
      KindPalette: begin
        stage_o.pal = 1'b1;
      end
      KindGrayAlpha: begin
        stage_o.red   = wide ? pair0 : {8'd0, byte0};
        stage_o.green = stage_o.red;
        stage_o.blue  = stage_o.red;
        stage_o.alpha = wide ? pair1 : {8'd0, byte1};
      end
      KindRgba: begin
        stage_o.red   = wide ? pair0 : {8'd0, byte0};
        stage_o.green = wide ? pair1 : {8'd0, byte1};
        stage_o.blue  = wide ? pair2 : {8'd0, byte2};
        stage_o.alpha = wide ? pair3 : {8'd0, byte3};
      end
      default: ; // unknown kind: all channels zero
    endcase
  end

endmodule

FILE: hw/rtl/png_pixel_unpack_to_rgba_top.sv
// PNG pixel unpack to RGBA.
// pix_i carries one transaction per pixel or palette write. func = 0 writes
// palette entry entry_index (RGB plus transparency byte) and gives no
// result. func = 1 converts pixel_bytes (first byte in bits 63:56) at
// x position pixel_position into one RGBA transaction on rgba_o.
// Configuration (color_kind, sample_depth, trans_count) must be written by
// the user through cfg_we_i / cfg_idx_i / cfg_data_i while the pipe is
// empty; the block does not enforce this. Pipeline: input register,
// unpack + palette RAM read, output register. Throughput is one
// transaction per clock while rgba_o is ready; the palette RAM takes one
// access per cycle (a write or a read), done in program order in stage B.
// When rgba_o stalls, each stage holds while the stages behind it fill;
// pix_i.ready drops only when all three stages hold data.
// Reset empties the pipe and sets color_kind to gray, sample_depth to 8
// and trans_count to 0. The palette RAM is not cleared; an entry must be
// written before a pixel refers to it.
module png_pixel_unpack_to_rgba_top
  import pngu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pngu_in_if.sink             pix_i,
  pngu_out_if.source          rgba_o
);

  // configuration
  logic [2:0] color_kind_q;
  logic [4:0] sample_depth_q;
  logic [8:0] trans_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_kind_q   <= KindGray;
      sample_depth_q <= Depth8;
      trans_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgColorKind:   color_kind_q   <= cfg_data_i[2:0];
        CfgSampleDepth: sample_depth_q <= cfg_data_i[4:0];
        CfgTransCount:  trans_count_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage moves when it is empty or the next one moves
  logic va_q, vb_q, vc_q;
  logic adv_a, adv_b, adv_c;

  assign adv_c       = !vc_q || rgba_o.ready;
  assign adv_b       = !vb_q || adv_c;
  assign adv_a       = !va_q || adv_b;
  assign pix_i.ready = adv_a;

  // stage A: input register
  logic        a_func_q;
  logic [63:0] a_px_q;
  logic [2:0]  a_pos_q;
  logic [7:0]  a_eidx_q;
  logic [31:0] a_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_a) begin
      va_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && pix_i.valid) begin
      a_func_q  <= pix_i.func;
      a_px_q    <= pix_i.pixel_bytes;
      a_pos_q   <= pix_i.pixel_position;
      a_eidx_q  <= pix_i.entry_index;
      a_entry_q <= {pix_i.entry_red, pix_i.entry_green, pix_i.entry_blue,
                    pix_i.entry_alpha};
    end
  end

  // stage B: unpack and palette access
  pngu_stage_t unp;
  pngu_stage_t b_q;

  pngu_unpack u_unpack (
    .pixel_bytes_i    (a_px_q),
    .pixel_position_i (a_pos_q),
    .color_kind_i     (color_kind_q),
    .sample_depth_i   (sample_depth_q),
    .trans_count_i    (trans_count_q),
    .stage_o          (unp)
  );

  // {red, green, blue, transparency} per entry
  logic [31:0] pal_mem [PaletteEntries];
  logic [31:0] rd_q;
  logic        wr_en;
  logic        rd_en;

  assign wr_en = adv_b && va_q && !a_func_q &&
                 ({1'b0, a_eidx_q} < PalCntW'(PaletteEntries));
  assign rd_en = adv_b && va_q && a_func_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem[a_eidx_q[PalIdxW-1:0]] <= a_entry_q;
    end
    if (rd_en) begin
      rd_q <= pal_mem[unp.idx[PalIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv_b) begin
      vb_q <= va_q && a_func_q;  // palette writes end here
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      b_q <= unp;
    end
  end

  // stage C: palette merge and output register
  logic [15:0] red_d, green_d, blue_d, alpha_d;
  logic [15:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    red_d   = b_q.red;
    green_d = b_q.green;
    blue_d  = b_q.blue;
    alpha_d = b_q.alpha;
    if (b_q.pal) begin
      if (b_q.in_range) begin
        red_d   = {8'd0, rd_q[31:24]};
        green_d = {8'd0, rd_q[23:16]};
        blue_d  = {8'd0, rd_q[15:8]};
        alpha_d = b_q.use_trans ? {8'd0, rd_q[7:0]} : AlphaOpaque;
      end else begin
        red_d   = '0;
        green_d = '0;
        blue_d  = '0;
        alpha_d = AlphaOpaque;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_c && vb_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  assign rgba_o.valid     = vc_q;
  assign rgba_o.red_out   = red_q;
  assign rgba_o.green_out = green_q;
  assign rgba_o.blue_out  = blue_q;
  assign rgba_o.alpha_out = alpha_q;

  // a palette write never sets the stage B valid bit
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && !a_func_q && adv_b) |=> !vb_q)
    else $error("palette write produced a pixel");

  // a stalled stage B keeps its pixel
  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !adv_c) |=> (vb_q && $stable(b_q) && $stable(rd_q)))
    else $error("stage B lost data under stall");

  // palette index past the table gives opaque black
  a_pal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_c && vb_q && b_q.pal && !b_q.in_range) |=>
      (rgba_o.red_out == '0 && rgba_o.alpha_out == AlphaOpaque))
    else $error("out-of-range palette index not opaque black");

endmodule

FILE: tb/tb_png_pixel_unpack_to_rgba_top.sv
module tb_png_pixel_unpack_to_rgba_top
  import pngu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes carried in the func field of a pixel transaction
  localparam logic FuncPalWrite = 1'b0;
  localparam logic FuncConvert  = 1'b1;

  // Watchdog, in clock cycles.
  localparam int unsigned CycleLimit = 600000;

  // Cycles to let pass after the last result so that a trailing palette
  // write (no result) has left the three-stage pipe.
  localparam int unsigned PipeFlush = 4;

  typedef struct packed {
    logic        func;
    logic [63:0] pixel_bytes;
    logic [2:0]  pixel_position;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [7:0]  entry_alpha;
  } pix_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } rgba_t;

  // Scoreboard: mirrors the palette RAM and the three registers, predicts
  // the RGBA output of each convert transaction at input acceptance and
  // checks output transactions in order.
  class rgba_scoreboard;
    logic [23:0] pal_rgb   [PaletteEntries];
    logic [7:0]  pal_alpha [PaletteEntries];
    logic [2:0]  kind;
    logic [4:0]  depth;
    logic [8:0]  tcount;
    rgba_t       expected_q[$];
    int unsigned errors;
    int unsigned matched;
    int unsigned pal_writes;

    function new();
      kind       = KindGray;
      depth      = Depth8;
      tcount     = '0;
      errors     = 0;
      matched    = 0;
      pal_writes = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
      case (r)
        CfgColorKind:   kind   = v[2:0];
        CfgSampleDepth: depth  = v[4:0];
        CfgTransCount:  tcount = v[8:0];
        default: ;
      endcase
    endfunction

    // Gray / palette sample: MSB-first within the first byte for 1, 2, 4 bits
    function logic [7:0] sub_sample(logic [63:0] px, logic [2:0] pos);
      logic [7:0]  b0;
      int unsigned per;
      int unsigned slot;
      int unsigned sh;
      b0 = px[63:56];
      if (depth != Depth1 && depth != Depth2 && depth != Depth4) return b0;
      per  = 8 / depth;
      slot = pos % per;
      sh   = 8 - depth * (slot + 1);
      return (b0 >> sh) & ((8'd1 << depth) - 8'd1);
    endfunction

    function void note_pixel(pix_item_t it);
      rgba_t      e;
      logic       wide;
      logic [7:0] ix;
      logic [63:0] px;
      if (it.func == FuncPalWrite) begin
        pal_rgb[it.entry_index]   = {it.entry_red, it.entry_green, it.entry_blue};
        pal_alpha[it.entry_index] = it.entry_alpha;
        pal_writes++;
        return;
      end
      px   = it.pixel_bytes;
      wide = (depth == Depth16);
      e    = '0;
      case (kind)
        KindGray: begin
          e.red   = wide ? px[63:48] : {8'd0, sub_sample(px, it.pixel_position)};
          e.green = e.red;
          e.blue  = e.red;
          e.alpha = AlphaOpaque;
        end
        KindRgb: begin
          e.red   = wide ? px[63:48] : {8'd0, px[63:56]};
          e.green = wide ? px[47:32] : {8'd0, px[55:48]};
          e.blue  = wide ? px[31:16] : {8'd0, px[47:40]};
          e.alpha = AlphaOpaque;
        end
        KindPalette: begin
          ix      = wide ? px[63:56] : sub_sample(px, it.pixel_position);
          e.red   = {8'd0, pal_rgb[ix][23:16]};
          e.green = {8'd0, pal_rgb[ix][15:8]};
          e.blue  = {8'd0, pal_rgb[ix][7:0]};
          e.alpha = ({1'b0, ix} < tcount) ? {8'd0, pal_alpha[ix]} : AlphaOpaque;
        end
        KindGrayAlpha: begin
          e.red   = wide ? px[63:48] : {8'd0, px[63:56]};
          e.green = e.red;
          e.blue  = e.red;
          e.alpha = wide ? px[47:32] : {8'd0, px[55:48]};
        end
        KindRgba: begin
          e.red   = wide ? px[63:48] : {8'd0, px[63:56]};
          e.green = wide ? px[47:32] : {8'd0, px[55:48]};
          e.blue  = wide ? px[31:16] : {8'd0, px[47:40]};
          e.alpha = wide ? px[15:0]  : {8'd0, px[39:32]};
        end
        default: e = '0;
      endcase
      expected_q.push_back(e);
    endfunction

    function void check_rgba(rgba_t got);
      rgba_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: rgba transaction with none expected: %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red) begin
        errors++;
        if (errors <= 40)
          $display("%0t: red mismatch exp %h got %h", $time, want.red, got.red);
      end
      if (got.green !== want.green) begin
        errors++;
        if (errors <= 40)
          $display("%0t: green mismatch exp %h got %h", $time, want.green, got.green);
      end
      if (got.blue !== want.blue) begin
        errors++;
        if (errors <= 40)
          $display("%0t: blue mismatch exp %h got %h", $time, want.blue, got.blue);
      end
      if (got.alpha !== want.alpha) begin
        errors++;
        if (errors <= 40)
          $display("%0t: alpha mismatch exp %h got %h", $time, want.alpha, got.alpha);
      end
      if (got === want) matched++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pngu_in_if  pix ();
  pngu_out_if rgba ();

  png_pixel_unpack_to_rgba_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .rgba_o     (rgba)
  );

  rgba_scoreboard sb = new();

  // Per-phase idle controls; both are cleared for the closing stretch
  bit          gap_on;
  bit          stall_on;
  int unsigned settings_used;
  int unsigned cycles;

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("png_pixel_unpack_to_rgba_top test failed");
      $finish;
    end
  end

  // Output side. ready is driven at the rising edge; valid/ready/payload
  // are sampled at the falling edge, where they are stable until the edge
  // that completes the transaction.
  initial begin
    rgba.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        rgba.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      rgba.ready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && rgba.valid && rgba.ready)
      sb.check_rgba({rgba.red_out, rgba.green_out, rgba.blue_out, rgba.alpha_out});
  end

  // Present one transaction on pix and hold it until accepted. valid is
  // left high on return: the caller either presents the next transaction
  // in the same step or lowers valid through drain_pipe.
  task automatic send_item(pix_item_t it);
    bit took;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pix.valid          <= 1'b1;
    pix.func           <= it.func;
    pix.pixel_bytes    <= it.pixel_bytes;
    pix.pixel_position <= it.pixel_position;
    pix.entry_index    <= it.entry_index;
    pix.entry_red      <= it.entry_red;
    pix.entry_green    <= it.entry_green;
    pix.entry_blue     <= it.entry_blue;
    pix.entry_alpha    <= it.entry_alpha;
    do begin
      @(negedge clk_i);
      took = pix.ready;
      @(posedge clk_i);
    end while (!took);
    sb.note_pixel(it);
  endtask

  // Stop sending and wait until every predicted pixel has come out, then
  // give any trailing palette write time to leave the pipe.
  task automatic drain_pipe();
    pix.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (PipeFlush) @(posedge clk_i);
  endtask

  // All three registers are rewritten on every change of setting, back to
  // back, with the pipe empty.
  task automatic set_format(logic [2:0] kind, logic [4:0] depth, logic [8:0] tcount);
    drain_pipe();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgColorKind;
    cfg_data_i <= CfgDataW'(kind);
    @(posedge clk_i);
    sb.set_reg(CfgColorKind, CfgDataW'(kind));
    cfg_idx_i  <= CfgSampleDepth;
    cfg_data_i <= CfgDataW'(depth);
    @(posedge clk_i);
    sb.set_reg(CfgSampleDepth, CfgDataW'(depth));
    cfg_idx_i  <= CfgTransCount;
    cfg_data_i <= tcount;
    @(posedge clk_i);
    sb.set_reg(CfgTransCount, tcount);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  task automatic convert(logic [63:0] px, logic [2:0] pos);
    pix_item_t it;
    it                = '0;
    it.func           = FuncConvert;
    it.pixel_bytes    = px;
    it.pixel_position = pos;
    send_item(it);
  endtask

  task automatic write_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] a);
    pix_item_t it;
    it             = '0;
    it.func        = FuncPalWrite;
    it.entry_index = idx;
    it.entry_red   = r;
    it.entry_green = g;
    it.entry_blue  = b;
    it.entry_alpha = a;
    it.pixel_bytes = {$urandom, $urandom};
    send_item(it);
  endtask

  // Random transaction; palette writes are more frequent in palette mode.
  // The other fields are random, with the first byte pushed to its extremes
  // now and then so palette indexes 0 and 255 show up often.
  function automatic pix_item_t random_item(bit pal_mode);
    pix_item_t it;
    it.func           = ($urandom_range(0, 99) < (pal_mode ? 20 : 8)) ? FuncPalWrite
                                                                        : FuncConvert;
    it.pixel_bytes    = {$urandom, $urandom};
    it.pixel_position = 3'($urandom_range(0, 7));
    it.entry_index    = 8'($urandom_range(0, 255));
    it.entry_red      = 8'($urandom);
    it.entry_green    = 8'($urandom);
    it.entry_blue     = 8'($urandom);
    it.entry_alpha    = 8'($urandom);
    if ($urandom_range(0, 9) == 0)
      it.pixel_bytes[63:56] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return it;
  endfunction

  task automatic random_setting(output logic [2:0] kind, output logic [4:0] depth,
                                output logic [8:0] tcount);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    kind = (pick < 8) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 4))
        0:       depth = Depth1;
        1:       depth = Depth2;
        2:       depth = Depth4;
        3:       depth = Depth8;
        default: depth = Depth16;
      endcase
    end else begin
      depth = 5'($urandom_range(0, 31));
    end
    case ($urandom_range(0, 4))
      0:       tcount = 9'd0;
      1:       tcount = 9'd256;
      2:       tcount = 9'($urandom_range(257, 511));
      default: tcount = 9'($urandom_range(0, 256));
    endcase
  endtask

  initial begin
    logic [2:0]  kind;
    logic [4:0]  depth;
    logic [8:0]  tcount;
    int unsigned n_items;
    int unsigned pause_at;

    // Every input known from time zero; reset held low at the start
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgColorKind;
    cfg_data_i         <= '0;
    pix.valid          <= 1'b0;
    pix.func           <= FuncPalWrite;
    pix.pixel_bytes    <= '0;
    pix.pixel_position <= '0;
    pix.entry_index    <= '0;
    pix.entry_red      <= '0;
    pix.entry_green    <= '0;
    pix.entry_blue     <= '0;
    pix.entry_alpha    <= '0;
    gap_on             = 1'b1;
    stall_on           = 1'b1;
    settings_used      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Palette RAM is not cleared by reset: load every entry before any
    // palette pixel can look one up. Entry 0 all zeros, entry 255 all ones.
    for (int i = 0; i < PaletteEntries; i++) begin
      if (i == 0)
        write_entry(8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      else if (i == PaletteEntries - 1)
        write_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else
        write_entry(8'(i), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end

    // Directed: gray at every depth incl. sub-byte slot positions
    set_format(KindGray, Depth8, 9'd0);
    convert(64'h0, 3'd0);
    convert('1, 3'd7);
    set_format(KindGray, Depth16, 9'd0);
    convert(64'h1234_5678_9ABC_DEF0, 3'd3);
    set_format(KindGray, Depth1, 9'd0);
    convert(64'h8100_0000_0000_0000, 3'd0);
    convert(64'h8100_0000_0000_0000, 3'd7);
    set_format(KindGray, Depth2, 9'd0);
    convert(64'hE4FF_FFFF_FFFF_FFFF, 3'd3);
    convert(64'hE4FF_FFFF_FFFF_FFFF, 3'd6);
    set_format(KindGray, Depth4, 9'd0);
    convert(64'hA5FF_FFFF_FFFF_FFFF, 3'd1);
    convert(64'hA5FF_FFFF_FFFF_FFFF, 3'd4);

    // Direct color types at 8 and 16 bits
    set_format(KindRgb, Depth16, 9'd0);
    convert(64'hFFFF_0000_8001_7FFE, 3'd5);
    set_format(KindGrayAlpha, Depth8, 9'd0);
    convert(64'h80FF_0102_0304_0506, 3'd2);
    set_format(KindRgba, Depth16, 9'd0);
    convert(64'h0102_0304_0506_0708, 3'd0);

    // Palette: index extremes, all-transparent and none-transparent counts,
    // first byte used as index at depth 16, sub-byte index, count above 256
    set_format(KindPalette, Depth8, 9'd256);
    write_entry(8'd200, 8'h12, 8'h34, 8'h56, 8'h00);
    convert(64'hC800_0000_0000_0000, 3'd0);
    convert(64'hFF00_0000_0000_0000, 3'd0);
    convert(64'h00FF_FFFF_FFFF_FFFF, 3'd0);
    set_format(KindPalette, Depth16, 9'd0);
    convert(64'hC8FF_FFFF_FFFF_FFFF, 3'd1);
    set_format(KindPalette, Depth1, 9'd511);
    convert(64'h0100_0000_0000_0000, 3'd7);

    // Unknown kind, odd depths treated as 8, sub-byte depth on rgb
    set_format(3'd7, Depth8, 9'd0);
    convert('1, 3'd0);
    set_format(KindGray, 5'd31, 9'd0);
    convert(64'h5A00_0000_0000_0000, 3'd2);
    set_format(KindRgb, Depth2, 9'd0);
    convert(64'hABCD_EF01_2345_6789, 3'd3);

    // Random phases: new setting each phase, idle behavior varies per phase,
    // and a mid-phase pause until the pipe is empty in the first phase and
    // then about a quarter of the others.
    for (int ph = 0; ph < 30; ph++) begin
      random_setting(kind, depth, tcount);
      set_format(kind, depth, tcount);
      gap_on   = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      n_items  = $urandom_range(20, 60);
      pause_at = (ph == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n_items - 1)
                                                        : n_items;
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) drain_pipe();
        send_item(random_item(kind == KindPalette));
      end
    end

    // Closing stretch at full rate: no gaps, no stalls
    gap_on   = 1'b0;
    stall_on = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      random_setting(kind, depth, tcount);
      set_format(kind, depth, tcount);
      for (int i = 0; i < 50; i++) send_item(random_item(kind == KindPalette));
    end

    drain_pipe();

    $display("Checked %0d pixel conversions, %0d palette writes, %0d register settings.",
             sb.matched, sb.pal_writes, settings_used);
    $display("Covered gray, rgb, palette, gray-alpha, rgba and unknown kinds at all depths.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("png_pixel_unpack_to_rgba_top test passed");
    end else begin
      $display("png_pixel_unpack_to_rgba_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pngu_pkg.sv
hw/rtl/pngu_in_if.sv
hw/rtl/pngu_out_if.sv
hw/rtl/pngu_unpack.sv
hw/rtl/png_pixel_unpack_to_rgba_top.sv
tb/tb_png_pixel_unpack_to_rgba_top.sv
